>>> src/cpu8_execute_unit_top_macros.svh
// assertion helpers for the execute unit
`ifndef CPU8_EXECUTE_UNIT_TOP_MACROS_SVH
`define CPU8_EXECUTE_UNIT_TOP_MACROS_SVH

// property that holds at every clock outside reset
`define CPU8EU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define CPU8EU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPU8EU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cpu8eu_pkg.sv
`timescale 1ns / 1ps
package cpu8eu_pkg;

  typedef enum logic [4:0] {
    FN_ADC    = 5'd0,
    FN_AND    = 5'd1,
    FN_ORA    = 5'd2,
    FN_EOR    = 5'd3,
    FN_CMP    = 5'd4,
    FN_CPX    = 5'd5,
    FN_CPY    = 5'd6,
    FN_LDA    = 5'd7,
    FN_LDX    = 5'd8,
    FN_LDY    = 5'd9,
    FN_ASL    = 5'd10,
    FN_LSR    = 5'd11,
    FN_ROL    = 5'd12,
    FN_ROR    = 5'd13,
    FN_INC    = 5'd14,
    FN_DEC    = 5'd15,
    FN_INX    = 5'd16,
    FN_INY    = 5'd17,
    FN_DEX    = 5'd18,
    FN_DEY    = 5'd19,
    FN_BIT    = 5'd20,
    FN_CLC    = 5'd21,
    FN_CLD    = 5'd22,
    FN_CLI    = 5'd23,
    FN_CLV    = 5'd24,
    FN_BRANCH = 5'd25,
    FN_PHA    = 5'd26,
    FN_PHP    = 5'd27,
    FN_PLA    = 5'd28,
    FN_PLP    = 5'd29,
    FN_NOP    = 5'd30
  } func_t;

  typedef enum logic [1:0] {
    COND_C = 2'd0,
    COND_Z = 2'd1,
    COND_N = 2'd2,
    COND_V = 2'd3
  } cond_t;

  // status bit positions: N V 1 B D I Z C
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] STATUS_RESET = 8'h24;

endpackage

>>> src/cpu8_execute_unit_top.sv
// the result is registered and is valid in the cycle after the input transfer
// throughput: one item per cycle while the result register is empty or being drained; all
//   flag and register logic sits between the architectural registers and a single result register
// ready stays high while the result register is empty or being drained
// reset: A, X, Y cleared, status 0x24 (I and bit 5 set), result register empty
`timescale 1ns / 1ps
`include "cpu8_execute_unit_top_macros.svh"
module cpu8_execute_unit_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] func,
  input  logic [7:0] operand,
  input  logic       on_memory,
  input  logic [1:0] cond_flag,
  input  logic       cond_sense,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] acc_out,
  output logic [7:0] x_out,
  output logic [7:0] y_out,
  output logic [7:0] status_out,
  output logic [7:0] mem_data,
  output logic       mem_write,
  output logic       branch_taken
);
  import cpu8eu_pkg::*;

  logic [7:0] acc, index_x, index_y, status;
  logic [7:0] acc_next, index_x_next, index_y_next, status_next;
  logic [7:0] md_next;
  logic       mw_next, taken_next;
  logic       in_fire;

  logic [8:0] adc_sum;
  logic [8:0] cmp_diff;
  logic [7:0] cmp_reg;
  logic [7:0] sh_src, sh_res;
  logic       sh_c;
  logic       cond_bit;

  function automatic logic [7:0] put_nz(input logic [7:0] st, input logic [7:0] v);
    logic [7:0] r;
    r = st;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign adc_sum = {1'b0, acc} + {1'b0, operand} + {8'h00, status[FLAG_C]};

  always_comb begin
    unique case (func_t'(func))
      FN_CPX:  cmp_reg = index_x;
      FN_CPY:  cmp_reg = index_y;
      default: cmp_reg = acc;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

  // shifter shared by the accumulator and memory forms
  assign sh_src = on_memory ? operand : acc;
  always_comb begin
    unique case (func_t'(func))
      FN_ASL: begin
        sh_res = {sh_src[6:0], 1'b0};
        sh_c   = sh_src[7];
      end
      FN_LSR: begin
        sh_res = {1'b0, sh_src[7:1]};
        sh_c   = sh_src[0];
      end
      FN_ROL: begin
        sh_res = {sh_src[6:0], status[FLAG_C]};
        sh_c   = sh_src[7];
      end
      default: begin
        sh_res = {status[FLAG_C], sh_src[7:1]};
        sh_c   = sh_src[0];
      end
    endcase
  end

  always_comb begin
    unique case (cond_t'(cond_flag))
      COND_C: cond_bit = status[FLAG_C];
      COND_Z: cond_bit = status[FLAG_Z];
      COND_N: cond_bit = status[FLAG_N];
      COND_V: cond_bit = status[FLAG_V];
      default: cond_bit = status[FLAG_C];
    endcase
  end

  always_comb begin
    acc_next     = acc;
    index_x_next = index_x;
    index_y_next = index_y;
    status_next  = status;
    md_next      = 8'h00;
    mw_next      = 1'b0;
    taken_next   = 1'b0;
    unique case (func_t'(func))
      FN_ADC: begin
        acc_next            = adc_sum[7:0];
        status_next[FLAG_C] = adc_sum[8];
        status_next[FLAG_V] = ~(acc[7] ^ operand[7]) & (acc[7] ^ adc_sum[7]);
        status_next         = put_nz(status_next, adc_sum[7:0]);
      end
      FN_AND: begin
        acc_next    = acc & operand;
        status_next = put_nz(status, acc & operand);
      end
      FN_ORA: begin
        acc_next    = acc | operand;
        status_next = put_nz(status, acc | operand);
      end
      FN_EOR: begin
        acc_next    = acc ^ operand;
        status_next = put_nz(status, acc ^ operand);
      end
      FN_CMP, FN_CPX, FN_CPY: begin
        status_next[FLAG_C] = !cmp_diff[8];
        status_next         = put_nz(status_next, cmp_diff[7:0]);
      end
      FN_LDA, FN_PLA: begin
        acc_next    = operand;
        status_next = put_nz(status, operand);
      end
      FN_LDX: begin
        index_x_next = operand;
        status_next  = put_nz(status, operand);
      end
      FN_LDY: begin
        index_y_next = operand;
        status_next  = put_nz(status, operand);
      end
      FN_ASL, FN_LSR, FN_ROL, FN_ROR: begin
        status_next[FLAG_C] = sh_c;
        status_next         = put_nz(status_next, sh_res);
        if (on_memory) begin
          md_next = sh_res;
          mw_next = 1'b1;
        end else begin
          acc_next = sh_res;
        end
      end
      FN_INC: begin
        md_next     = operand + 8'd1;
        mw_next     = 1'b1;
        status_next = put_nz(status, operand + 8'd1);
      end
      FN_DEC: begin
        md_next     = operand - 8'd1;
        mw_next     = 1'b1;
        status_next = put_nz(status, operand - 8'd1);
      end
      FN_INX: begin
        index_x_next = index_x + 8'd1;
        status_next  = put_nz(status, index_x + 8'd1);
      end
      FN_INY: begin
        index_y_next = index_y + 8'd1;
        status_next  = put_nz(status, index_y + 8'd1);
      end
      FN_DEX: begin
        index_x_next = index_x - 8'd1;
        status_next  = put_nz(status, index_x - 8'd1);
      end
      FN_DEY: begin
        index_y_next = index_y - 8'd1;
        status_next  = put_nz(status, index_y - 8'd1);
      end
      FN_BIT: begin
        status_next[FLAG_N] = operand[7];
        status_next[FLAG_V] = operand[6];
        status_next[FLAG_Z] = ((acc & operand) == 8'h00);
      end
      FN_CLC: status_next[FLAG_C] = 1'b0;
      FN_CLD: status_next[FLAG_D] = 1'b0;
      FN_CLI: status_next[FLAG_I] = 1'b0;
      FN_CLV: status_next[FLAG_V] = 1'b0;
      FN_BRANCH: taken_next = (cond_bit == cond_sense);
      FN_PHA: begin
        md_next = acc;
        mw_next = 1'b1;
      end
      FN_PHP: begin
        md_next         = status;
        md_next[FLAG_B] = 1'b1;
        md_next[FLAG_U] = 1'b1;
        mw_next         = 1'b1;
      end
      FN_PLP: begin
        // pulled byte: break bit dropped, bit 5 always set
        status_next         = operand;
        status_next[FLAG_B] = 1'b0;
        status_next[FLAG_U] = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= 8'h00;
      index_x <= 8'h00;
      index_y <= 8'h00;
      status  <= STATUS_RESET;
    end else if (in_fire) begin
      acc     <= acc_next;
      index_x <= index_x_next;
      index_y <= index_y_next;
      status  <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_out      <= acc_next;
      x_out        <= index_x_next;
      y_out        <= index_y_next;
      status_out   <= status_next;
      mem_data     <= md_next;
      mem_write    <= mw_next;
      branch_taken <= taken_next;
    end
  end

  `CPU8EU_ASSERT_ALWAYS(a_status_bit5, status[FLAG_U], "status bit 5 lost")
  `CPU8EU_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid, "accepted item gave no result")
  `CPU8EU_ASSERT_IMPL(a_no_write_zero_data, out_valid && !mem_write, mem_data == 8'h00,
                      "mem_data not zero without a write")
  `CPU8EU_ASSERT_IMPL(a_branch_no_write, out_valid && branch_taken, !mem_write,
                      "branch result carries a memory write")

endmodule
